[rtl/core/zon_pkg.sv]
package zon_pkg;

  // lexer modes
  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_SLASH     = 4'd1;
  localparam logic [3:0] M_COMMENT   = 4'd2;
  localparam logic [3:0] M_STR       = 4'd3;
  localparam logic [3:0] M_ESC       = 4'd4;
  localparam logic [3:0] M_IDENT     = 4'd5;
  localparam logic [3:0] M_ZERO      = 4'd6;
  localparam logic [3:0] M_BIN       = 4'd7;
  localparam logic [3:0] M_OCT       = 4'd8;
  localparam logic [3:0] M_HEX       = 4'd9;
  localparam logic [3:0] M_DEC       = 4'd10;
  localparam logic [3:0] M_ERR_SLASH = 4'd11;
  localparam logic [3:0] M_ERR_ZERO  = 4'd12;

  // token kinds
  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_DOT    = 4'd1;
  localparam logic [3:0] K_LBRACE = 4'd2;
  localparam logic [3:0] K_RBRACE = 4'd3;
  localparam logic [3:0] K_EQUALS = 4'd4;
  localparam logic [3:0] K_STRING = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_IDENT  = 4'd7;
  localparam logic [3:0] K_BIN    = 4'd8;
  localparam logic [3:0] K_OCT    = 4'd9;
  localparam logic [3:0] K_HEX    = 4'd10;
  localparam logic [3:0] K_INT    = 4'd11;

  // error codes
  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_SLASH = 2'd1;
  localparam logic [1:0] E_ZERO  = 2'd2;

  // characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] chr;
    logic       has_char;
    logic       first;
    logic       last;
    logic [1:0] err;
  } tok_t;

  // outcome of lexing one input beat
  typedef struct packed {
    logic [1:0]  num;
    tok_t        tok0;
    tok_t        tok1;
    logic [3:0]  mode_nxt;
    logic [15:0] count_nxt;
  } step_t;

endpackage

[rtl/core/zon_in_if.sv]
interface zon_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_marker;

  modport source (output valid, output ch, output end_marker, input ready);
  modport sink (input valid, input ch, input end_marker, output ready);
endinterface

[rtl/core/zon_out_if.sv]
interface zon_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_char;
  logic       has_char;
  logic       token_first;
  logic       token_last;
  logic [1:0] error_code;

  modport source (output valid, output token_kind, output token_char, output has_char,
                  output token_first, output token_last, output error_code, input ready);
  modport sink (input valid, input token_kind, input token_char, input has_char,
                input token_first, input token_last, input error_code, output ready);
endinterface

[rtl/core/zon_lex_step.sv]
module zon_lex_step (
  input  logic [7:0]     ch,
  input  logic           end_marker,
  input  logic [3:0]     mode,
  input  logic [15:0]    count,
  input  logic [15:0]    limit,
  output zon_pkg::step_t res
);
  import zon_pkg::*;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic continues(input logic [3:0] m, input logic [7:0] c);
    logic r;
    unique case (m)
      M_IDENT: r = is_alpha(c) || is_digit(c) || c == CH_UNDER;
      M_BIN:   r = c == 8'h30 || c == 8'h31 || c == CH_UNDER;
      M_OCT:   r = c >= 8'h30 && c <= 8'h37;
      M_HEX:   r = is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
      default: r = is_digit(c);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] mode_kind(input logic [3:0] m);
    logic [3:0] k;
    unique case (m)
      M_STR, M_ESC: k = K_STRING;
      M_IDENT:      k = K_IDENT;
      M_BIN:        k = K_BIN;
      M_OCT:        k = K_OCT;
      M_HEX:        k = K_HEX;
      default:      k = K_INT;
    endcase
    return k;
  endfunction

  function automatic tok_t mk(input logic [3:0] k, input logic [7:0] c, input logic h,
                              input logic f, input logic l, input logic [1:0] e);
    tok_t t;
    t.kind = k; t.chr = c; t.has_char = h; t.first = f; t.last = l; t.err = e;
    return t;
  endfunction

  logic       slot_ok;
  logic [3:0] d_mode;
  logic       d_emit;
  logic       d_inc;
  tok_t       d_tok;
  logic       inc;

  assign slot_ok = ({1'b0, count} + 17'd1) < {1'b0, limit};

  // start of a new token from the idle state
  always_comb begin
    d_mode = M_IDLE;
    d_emit = 1'b0;
    d_inc  = 1'b0;
    d_tok  = mk(K_END, ch, 1'b1, 1'b1, 1'b1, E_NONE);
    if (slot_ok) begin
      priority if (ch == CH_SLASH) begin
        d_mode = M_SLASH;
      end else if (ch == CH_DOT) begin
        d_emit = 1'b1; d_inc = 1'b1; d_tok.kind = K_DOT;
      end else if (ch == CH_LBRACE) begin
        d_emit = 1'b1; d_inc = 1'b1; d_tok.kind = K_LBRACE;
      end else if (ch == CH_RBRACE) begin
        d_emit = 1'b1; d_inc = 1'b1; d_tok.kind = K_RBRACE;
      end else if (ch == CH_EQUALS) begin
        d_emit = 1'b1; d_inc = 1'b1; d_tok.kind = K_EQUALS;
      end else if (ch == CH_COMMA) begin
        d_emit = 1'b1; d_inc = 1'b1; d_tok.kind = K_COMMA;
      end else if (ch == CH_QUOTE) begin
        d_emit = 1'b1; d_inc = 1'b1; d_mode = M_STR;
        d_tok  = mk(K_STRING, 8'h00, 1'b0, 1'b1, 1'b0, E_NONE);
      end else if (ch == CH_ZERO) begin
        d_mode = M_ZERO;
      end else if (is_alpha(ch) || ch == CH_UNDER) begin
        d_emit = 1'b1; d_inc = 1'b1; d_mode = M_IDENT;
        d_tok  = mk(K_IDENT, ch, 1'b1, 1'b1, 1'b0, E_NONE);
      end else if (is_digit(ch)) begin
        d_emit = 1'b1; d_inc = 1'b1; d_mode = M_DEC;
        d_tok  = mk(K_INT, ch, 1'b1, 1'b1, 1'b0, E_NONE);
      end else begin
        d_mode = M_IDLE;
      end
    end
  end

  // one transition of the lexer
  always_comb begin
    res.num      = 2'd0;
    res.tok0     = d_tok;
    res.tok1     = d_tok;
    res.mode_nxt = mode;
    inc          = 1'b0;
    if (end_marker) begin
      res.mode_nxt = M_IDLE;
      unique case (mode)
        M_STR, M_ESC, M_IDENT, M_BIN, M_OCT, M_HEX, M_DEC: begin
          res.num  = 2'd2;
          res.tok0 = mk(mode_kind(mode), 8'h00, 1'b0, 1'b0, 1'b1, E_NONE);
          res.tok1 = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_NONE);
        end
        M_SLASH, M_ERR_SLASH: begin
          res.num  = 2'd1;
          res.tok0 = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_SLASH);
        end
        M_ZERO, M_ERR_ZERO: begin
          res.num  = 2'd1;
          res.tok0 = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_ZERO);
        end
        default: begin
          res.num  = 2'd1;
          res.tok0 = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_NONE);
        end
      endcase
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (ch == CH_SLASH) begin
            res.mode_nxt = M_COMMENT;
          end else begin
            res.mode_nxt = M_ERR_SLASH;
            res.num      = 2'd1;
            res.tok0     = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_SLASH);
          end
        end
        M_COMMENT: begin
          if (ch == CH_LF) res.mode_nxt = M_IDLE;
        end
        M_STR: begin
          res.num = 2'd1;
          if (ch == CH_QUOTE) begin
            res.mode_nxt = M_IDLE;
            res.tok0     = mk(K_STRING, 8'h00, 1'b0, 1'b0, 1'b1, E_NONE);
          end else begin
            if (ch == CH_BSLASH) res.mode_nxt = M_ESC;
            res.tok0 = mk(K_STRING, ch, 1'b1, 1'b0, 1'b0, E_NONE);
          end
        end
        M_ESC: begin
          res.mode_nxt = M_STR;
          res.num      = 2'd1;
          res.tok0     = mk(K_STRING, ch, 1'b1, 1'b0, 1'b0, E_NONE);
        end
        M_ZERO: begin
          res.num = 2'd2;
          priority if (ch == CH_B) begin
            res.mode_nxt = M_BIN;
            res.tok0     = mk(K_BIN, CH_ZERO, 1'b1, 1'b1, 1'b0, E_NONE);
          end else if (ch == CH_O) begin
            res.mode_nxt = M_OCT;
            res.tok0     = mk(K_OCT, CH_ZERO, 1'b1, 1'b1, 1'b0, E_NONE);
          end else if (ch == CH_X) begin
            res.mode_nxt = M_HEX;
            res.tok0     = mk(K_HEX, CH_ZERO, 1'b1, 1'b1, 1'b0, E_NONE);
          end else begin
            res.mode_nxt = M_ERR_ZERO;
            res.num      = 2'd1;
            res.tok0     = mk(K_END, 8'h00, 1'b0, 1'b1, 1'b1, E_ZERO);
          end
          inc      = (res.num == 2'd2);
          res.tok1 = mk(res.tok0.kind, ch, 1'b1, 1'b0, 1'b0, E_NONE);
        end
        M_IDENT, M_BIN, M_OCT, M_HEX, M_DEC: begin
          if (continues(mode, ch)) begin
            res.num  = 2'd1;
            res.tok0 = mk(mode_kind(mode), ch, 1'b1, 1'b0, 1'b0, E_NONE);
          end else begin
            // close the token, then lex the byte that ended it
            res.tok0     = mk(mode_kind(mode), 8'h00, 1'b0, 1'b0, 1'b1, E_NONE);
            res.tok1     = d_tok;
            res.num      = d_emit ? 2'd2 : 2'd1;
            res.mode_nxt = d_mode;
            inc          = d_inc;
          end
        end
        M_ERR_SLASH, M_ERR_ZERO: begin
          res.num = 2'd0;
        end
        default: begin
          res.tok0     = d_tok;
          res.num      = d_emit ? 2'd1 : 2'd0;
          res.mode_nxt = d_mode;
          inc          = d_inc;
        end
      endcase
    end

    // started-token count, saturating; cleared by the end mark
    if (end_marker) begin
      res.count_nxt = 16'd0;
    end else if (inc && count != 16'hFFFF) begin
      res.count_nxt = count + 16'd1;
    end else begin
      res.count_nxt = count;
    end
  end

endmodule

[rtl/core/zon_token_lexer_core.sv]
// Streaming ZON lexer. One beat on in_if is one source byte, or an end mark;
// each accepted beat produces zero, one or two token beats on out_if, which
// are stored in a four-entry result queue. The lexer state advances in the
// same cycle a beat is accepted, so input runs at one byte per cycle while the
// queue has room for two results (at most two entries occupied). Sustained
// rate is one byte per cycle as long as the stream averages at most one token
// beat per byte and the sink takes a beat every cycle; a byte that yields two
// beats (a radix prefix, or a token closed by a token-starting byte) borrows
// one queue slot, and back-to-back double beats stall input.
// With the queue empty, results appear on out_if the cycle after the byte is
// accepted.
// cfg_we/cfg_wdata set limit_r; write it only while the block is idle.
module zon_token_lexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  zon_in_if.sink      in_if,
  zon_out_if.source   out_if
);
  import zon_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  logic [15:0]   limit_r;
  logic [3:0]    mode_r;
  logic [15:0]   count_r;
  tok_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] head_r, tail_r;
  logic [PW:0]   fill_r, fill_nxt;
  step_t         step;
  logic          in_fire, out_fire;
  logic [PW-1:0] tail_p1;
  tok_t          out_tok;

  zon_lex_step u_step (
    .ch         (in_if.ch),
    .end_marker (in_if.end_marker),
    .mode       (mode_r),
    .count      (count_r),
    .limit      (limit_r),
    .res        (step)
  );

  assign in_if.ready = (fill_r <= (PW+1)'(QUEUE_DEPTH - 2));
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;
  assign tail_p1     = tail_r + PW'(1);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      count_r <= 16'd0;
    end else if (in_fire) begin
      mode_r  <= step.mode_nxt;
      count_r <= step.count_nxt;
    end
  end

  // result queue: up to two pushes, one pop per cycle
  always_comb begin
    fill_nxt = fill_r;
    if (in_fire) fill_nxt = fill_nxt + {{(PW-1){1'b0}}, step.num};
    if (out_fire) fill_nxt = fill_nxt - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (out_fire) head_r <= head_r + PW'(1);
      if (in_fire) tail_r <= tail_r + PW'(step.num);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step.num != 2'd0) q_r[tail_r] <= step.tok0;
    if (in_fire && step.num == 2'd2) q_r[tail_p1] <= step.tok1;
  end

  assign out_tok            = q_r[head_r];
  assign out_if.valid       = (fill_r != '0);
  assign out_if.token_kind  = out_tok.kind;
  assign out_if.token_char  = out_tok.chr;
  assign out_if.has_char    = out_tok.has_char;
  assign out_if.token_first = out_tok.first;
  assign out_if.token_last  = out_tok.last;
  assign out_if.error_code  = out_tok.err;

  // queue never overflows
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (PW+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // an end mark restarts the stream
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.end_marker |=> mode_r == M_IDLE && count_r == 16'd0)
    else $error("end mark did not reset lexer state");

  // error codes travel only on end-kind beats
  a_err_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.error_code != E_NONE |-> out_if.token_kind == K_END)
    else $error("error code on a non-end token");

  // end-kind beats are complete single-beat tokens with no character
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.token_kind == K_END
      |-> out_if.token_first && out_if.token_last && !out_if.has_char)
    else $error("malformed end token");

endmodule
